@@ rtl/olid_pkg.sv @@
// Shared types and codes for the ordered list block.
package olid_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [4:0]          position;
        logic signed [31:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  read_value;
        logic [4:0]          entry_count;
    } t_out_item;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                ins_en;
        logic                del_en;
        logic                rd_en;
        logic [4:0]          pos_m1;
        logic signed [31:0]  value;
    } t_cell_ctl;

endpackage

@@ rtl/ordered_list_insert_delete.sv @@
// Top level of the ordered list: a row of entry cells with a registered result.
//
//   Channel   Direction   Handshake                     Payload
//   input     in          i_in_valid / o_in_stall       i_in_item  (t_in_item)
//   output    out         o_out_valid / i_out_stall     o_out_item (t_out_item)
//
// All cells shift, match or select in parallel and the result is registered at
// the accepting edge, so a new item is taken each cycle while the output is not
// stalled. The delete match ripples along the row of cells within that cycle.
// Reset clears the count and the result valid; cell contents are not cleared.
// A stalled result holds, and the input is stalled only while it does.
module ordered_list_insert_delete #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  olid_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output olid_pkg::t_out_item o_out_item
);
    import olid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic               accept;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    t_out_item          r_out_item;
    t_out_item          result;
    t_cell_ctl          ctl;

    logic signed [31:0] cell_value [CAPACITY];
    logic               found_chain [CAPACITY+1];
    logic signed [31:0] rd_chain [CAPACITY+1];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign found_chain[0] = 1'b0;
    assign rd_chain[0]    = '0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;

        if (k == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_inner_l
            assign left_value = cell_value[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_inner_r
            assign right_value = cell_value[k+1];
        end

        olid_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_count       (r_count),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .i_found       (found_chain[k]),
            .o_found       (found_chain[k+1]),
            .i_rd          (rd_chain[k]),
            .o_rd          (rd_chain[k+1]),
            .o_value       (cell_value[k])
        );
    end

    olid_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_accept     (accept),
        .i_item       (i_in_item),
        .i_count      (r_count),
        .i_found      (found_chain[CAPACITY]),
        .i_rd_value   (rd_chain[CAPACITY]),
        .o_ctl        (ctl),
        .o_count_next (n_count),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= result;
        end
    end

endmodule

@@ rtl/olid_cell.sv @@
// One list cell: holds one entry, matches, and shifts with its neighbors.
module olid_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                  i_clk,
    input  olid_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic signed [31:0]    i_left_value,
    input  logic signed [31:0]    i_right_value,
    input  logic                  i_found,
    output logic                  o_found,
    input  logic signed [31:0]    i_rd,
    output logic signed [31:0]    o_rd,
    output logic signed [31:0]    o_value
);
    import olid_pkg::*;

    localparam bit          LOW  = (IDX < 32);
    localparam logic [4:0]  IDX5 = 5'(IDX);
    localparam logic [CW:0] IDXC = (CW+1)'(IDX);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               live;
    logic               hit;
    logic               after;

    assign live  = {1'b0, i_count} > IDXC;
    assign hit   = LOW && (i_ctl.pos_m1 == IDX5);
    assign after = !LOW || (IDX5 > i_ctl.pos_m1);

    // The found flag ripples right: on a delete, the matching cell and every later
    // cell pull their right neighbor in to close the gap.
    assign o_found = i_found | (live && (r_value == i_ctl.value));
    assign o_rd    = i_rd | ((i_ctl.rd_en && hit) ? r_value : '0);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        priority if (i_ctl.ins_en) begin
            if (hit) begin
                n_value = i_ctl.value;
            end else if (after) begin
                n_value = i_left_value;
            end
        end else if (i_ctl.del_en && o_found) begin
            n_value = i_right_value;
        end else begin
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/olid_ctrl.sv @@
// Command decode, bound checks, next count and result assembly.
module olid_ctrl #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF,
    parameter int CW       = 5
) (
    input  logic                 i_accept,
    input  olid_pkg::t_in_item   i_item,
    input  logic [CW-1:0]        i_count,
    input  logic                 i_found,
    input  logic signed [31:0]   i_rd_value,
    output olid_pkg::t_cell_ctl  o_ctl,
    output logic [CW-1:0]        o_count_next,
    output olid_pkg::t_out_item  o_result
);
    import olid_pkg::*;

    localparam int PW = ((CW > 5) ? CW : 5) + 1;

    logic [PW-1:0] pos_w;
    logic [PW-1:0] cnt_w;
    logic          ins_pos_ok;
    logic          full;
    logic          rd_ok;

    assign pos_w      = PW'(i_item.position);
    assign cnt_w      = PW'(i_count);
    assign ins_pos_ok = (i_item.position != 5'd0) && (pos_w <= cnt_w + PW'(1));
    assign full       = cnt_w >= PW'(CAPACITY);
    assign rd_ok      = (i_item.position != 5'd0) && (pos_w <= cnt_w);

    // Cell controls depend only on the command and the count, never on the
    // cells' own outputs.
    always_comb begin
        o_ctl        = '0;
        o_ctl.pos_m1 = i_item.position - 5'd1;
        o_ctl.value  = i_item.value;
        o_ctl.ins_en = i_accept && (i_item.cmd == CMD_INSERT) && ins_pos_ok && !full;
        o_ctl.del_en = i_accept && (i_item.cmd == CMD_DELETE);
        o_ctl.rd_en  = (i_item.cmd == CMD_READ) && rd_ok;
    end

    always_comb begin
        o_count_next        = i_count;
        o_result.status     = ST_OK;
        o_result.read_value = '0;
        unique case (i_item.cmd)
            CMD_INSERT: begin
                if (!ins_pos_ok) begin
                    o_result.status = ST_BADPOS;
                end else if (full) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_count_next = i_count + CW'(1);
                end
            end
            CMD_DELETE: begin
                if (!i_found) begin
                    o_result.status = ST_NOTFOUND;
                end else begin
                    o_count_next = i_count - CW'(1);
                end
            end
            CMD_READ: begin
                if (!rd_ok) begin
                    o_result.status = ST_BADPOS;
                end else begin
                    o_result.read_value = i_rd_value;
                end
            end
            default: begin
                o_result.status = ST_BADPOS;
            end
        endcase
        o_result.entry_count = 5'(o_count_next);
    end

endmodule

@@ rtl/olid_checker.sv @@
// Port-level checks for the ordered list, with the bind that attaches them.
module olid_checker #(
    parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input olid_pkg::t_out_item o_out_item
);
    import olid_pkg::*;

    localparam logic [4:0] CAP5 = 5'(CAPACITY);

    // A result that waits must stay offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A full report means the list really holds CAPACITY entries.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == ST_FULL) |-> o_out_item.entry_count == CAP5)
        else $error("full status with wrong count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != ST_OK) |-> o_out_item.read_value == 0)
        else $error("failed item carries read data");

    // With the output free, the input is never stalled.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind ordered_list_insert_delete olid_checker #(
    .CAPACITY (CAPACITY)
) u_olid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for the ordered list block: table-driven and random items.
`timescale 1ns / 1ps

module tb_top;
    import olid_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int N_RANDOM     = 1525;
    localparam int HOLD_AT      = 400;
    localparam int DRAIN_AT     = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 3000;
    localparam int PRINT_LIMIT  = 100;

    // The block answers an unused command code with a position error.
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    typedef enum {LIST_GROW, LIST_SHRINK, LIST_CHURN} t_list_phase;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_BURSTY} t_stall_mode;

    typedef struct {
        t_in_item  item;
        int        reps;
        bit        fixed;
        t_out_item want;
    } t_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic signed [31:0] list_vals [CAP];
    int                 list_len = 0;
    t_out_item          pending_results [$];
    int                 fail_count = 0;
    int                 stuck_cycles = 0;
    bit                 hold_req = 1'b0;

    t_row plan [0:24] = '{
        '{'{CMD_READ,   5'd1,  32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd0}},
        '{'{CMD_DELETE, 5'd0,  32'sd5},           1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd0}},
        '{'{CMD_INSERT, 5'd0,  32'sd1},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd0}},
        '{'{CMD_INSERT, 5'd2,  32'sd1},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd0}},
        '{'{CMD_UNDEF,  5'd31, -32'sd1},          1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd0}},
        '{'{CMD_INSERT, 5'd1,  32'sh7fffffff},    1,  1'b1, '{ST_OK,       32'sd0, 5'd1}},
        '{'{CMD_INSERT, 5'd1,  32'sh80000000},    1,  1'b1, '{ST_OK,       32'sd0, 5'd2}},
        '{'{CMD_INSERT, 5'd3,  -32'sd1},          1,  1'b1, '{ST_OK,       32'sd0, 5'd3}},
        '{'{CMD_READ,   5'd1,  32'sd0},           1,  1'b1, '{ST_OK, 32'sh80000000, 5'd3}},
        '{'{CMD_READ,   5'd3,  32'sd0},           1,  1'b1, '{ST_OK,      -32'sd1, 5'd3}},
        '{'{CMD_READ,   5'd4,  32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd3}},
        '{'{CMD_READ,   5'd0,  32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd3}},
        '{'{CMD_INSERT, 5'd2,  32'sd0},           1,  1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_DELETE, 5'd0,  32'sh7fffffff},    1,  1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_DELETE, 5'd9,  32'sd12345},       1,  1'b1, '{ST_NOTFOUND, 32'sd0, 5'd3}},
        '{'{CMD_INSERT, 5'd1,  32'sd42},          13, 1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_INSERT, 5'd17, 32'sh55555555},    1,  1'b1, '{ST_FULL,     32'sd0, 5'd16}},
        '{'{CMD_INSERT, 5'd31, 32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd16}},
        '{'{CMD_INSERT, 5'd18, 32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd16}},
        '{'{CMD_READ,   5'd16, 32'sd0},           1,  1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_READ,   5'd17, 32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd16}},
        '{'{CMD_UNDEF,  5'd0,  32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd16}},
        '{'{CMD_DELETE, 5'd31, 32'sd42},          1,  1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_DELETE, 5'd0,  32'sh80000000},    1,  1'b0, '{ST_OK,       32'sd0, 5'd0}},
        '{'{CMD_READ,   5'd31, 32'sd0},           1,  1'b1, '{ST_BADPOS,   32'sd0, 5'd14}}
    };

    ordered_list_insert_delete u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 clk = ~clk;

    // Applies one command to the list copy and returns the result it yields.
    function automatic t_out_item apply_to_list(input t_in_item it);
        t_out_item r;
        int        pos;
        int        at;
        int        k;
        r.status     = ST_OK;
        r.read_value = '0;
        pos          = int'(it.position);
        at           = -1;
        case (it.cmd)
            CMD_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = list_len; k >= pos; k--)
                        list_vals[k] = list_vals[k - 1];
                    list_vals[pos - 1] = it.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                for (k = 0; k < list_len; k++)
                    if (at < 0 && list_vals[k] == it.value)
                        at = k;
                if (at < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    for (k = at; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k + 1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (pos < 1 || pos > list_len)
                    r.status = ST_BADPOS;
                else
                    r.read_value = list_vals[pos - 1];
            end
            default: r.status = ST_BADPOS;
        endcase
        r.entry_count = 5'(list_len);
        return r;
    endfunction

    // Values come mostly from a narrow pool so that deletes find matches.
    function automatic t_in_item make_random_item(input t_list_phase phase);
        t_in_item it;
        int       ins_pct;
        int       del_pct;
        int       pick;
        case (phase)
            LIST_GROW:   begin ins_pct = 60; del_pct = 12; end
            LIST_SHRINK: begin ins_pct = 15; del_pct = 60; end
            default:     begin ins_pct = 35; del_pct = 30; end
        endcase
        case ($urandom_range(7))
            0:       it.value = $urandom;
            1:       it.value = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: it.value = int'($urandom_range(8)) - 4;
        endcase
        pick = $urandom_range(99);
        if (pick < ins_pct) begin
            it.cmd      = CMD_INSERT;
            it.position = ($urandom_range(9) < 8) ? 5'($urandom_range(list_len + 1))
                                                  : 5'($urandom_range(31));
        end else if (pick < ins_pct + del_pct) begin
            it.cmd      = CMD_DELETE;
            it.position = 5'($urandom_range(31));
            if (list_len > 0 && $urandom_range(9) < 7)
                it.value = list_vals[$urandom_range(list_len - 1)];
        end else if (pick < 96) begin
            it.cmd      = CMD_READ;
            it.position = ($urandom_range(9) < 8) ? 5'($urandom_range(list_len))
                                                  : 5'($urandom_range(31));
        end else begin
            it.cmd      = CMD_UNDEF;
            it.position = 5'($urandom_range(31));
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
        fail_count++;
    endtask

    // Offers one item from the next falling edge and holds it until taken.
    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item predicted;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = apply_to_list(it);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    initial begin
        t_list_phase phase;
        int          phase_left;
        int          burst_left;
        phase      = LIST_GROW;
        phase_left = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
            repeat (plan[r].reps)
                send_item(plan[r].item, plan[r].fixed, plan[r].want);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (phase_left == 0) begin
                phase      = t_list_phase'($urandom_range(2));
                phase_left = $urandom_range(20, 80);
            end
            phase_left--;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(9) < 7)
                    idle_for($urandom_range(1, 12));
            end
            burst_left--;
            if (i == HOLD_AT)
                hold_req = 1'b1;
            if (i == DRAIN_AT) begin
                idle_for(1);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            send_item(make_random_item(phase), 1'b0, '0);
        end

        idle_for(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver stall patterns, with one long hold-off that fills the block.
    initial begin
        t_stall_mode mode;
        int          left;
        int          tick;
        bit          held;
        mode = STALL_NONE;
        left = 0;
        tick = 0;
        held = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                held = 1'b1;
            end else begin
                if (left == 0) begin
                    mode = t_stall_mode'($urandom_range(4));
                    left = $urandom_range(20, 120);
                end
                left--;
                tick++;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(99) < 30);
                    STALL_HEAVY:  out_stall <= ($urandom_range(99) < 80);
                    STALL_TOGGLE: out_stall <= tick[0];
                    default:      out_stall <= ((tick % 8) < 3);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", '0, 32'(out_item));
            end else begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(out_item.status));
                if (out_item.read_value !== want.read_value)
                    report_mismatch("read_value", want.read_value, out_item.read_value);
                if (out_item.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(want.entry_count),
                                    32'(out_item.entry_count));
            end
        end
    end

    // Ends the run if neither channel moves an item for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
